// ----- design/tmq_pkg.sv -----
`default_nettype none

package tmq_pkg;

  localparam int TIMER_SLOTS = 32;
  localparam int SLOT_BITS   = $clog2(TIMER_SLOTS);
  localparam int CNT_BITS    = $clog2(TIMER_SLOTS + 1);

  localparam int ID_BITS     = 16;
  localparam int DELAY_BITS  = 16;
  localparam int REQ_BITS    = 2;
  localparam int KIND_BITS   = 3;
  localparam int COUNT_BITS  = 6;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_ADD        = 2'd0,
    REQ_CANCEL     = 2'd1,
    REQ_CANCEL_ALL = 2'd2,
    REQ_TICK       = 2'd3
  } req_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_EXPIRED = 3'd2,
    KIND_ABORTED = 3'd3,
    KIND_MISS    = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/timer_queue_manager.sv -----
// Each request is a scan of the slot table: add scans up to the first free slot, cancel
// up to the matching slot, cancel all and tick the whole table; output stalls add to this.
// The block takes one item at a time; the slot scan visits one table slot per cycle
// while a pending result beat is not held back by an output stall.
// Reset (rst_n, synchronous, active low): table empty, id counter zero, sequencer
// idle, no result beat pending; slot ident, period and remaining are not reset.
`default_nettype none

module timer_queue_manager (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [tmq_pkg::REQ_BITS-1:0]     in_req_type,
  input  wire logic [tmq_pkg::DELAY_BITS-1:0]   in_delay_ms,
  input  wire logic                             in_is_periodic,
  input  wire logic [tmq_pkg::ID_BITS-1:0]      in_timer_id,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [tmq_pkg::KIND_BITS-1:0]         out_kind,
  output logic [tmq_pkg::ID_BITS-1:0]           out_result_id,
  output logic [tmq_pkg::COUNT_BITS-1:0]        out_fired_count,
  output logic                                  out_last
);
  import tmq_pkg::*;

  state_t                state_r, state_nxt;
  req_t                  req_r;
  logic [DELAY_BITS-1:0] delay_r;
  logic                  periodic_r;
  logic [ID_BITS-1:0]    want_r;
  logic [SLOT_BITS-1:0]  idx_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [ID_BITS-1:0]    next_ident_r;

  logic [TIMER_SLOTS-1:0] slot_valid_r;
  logic [TIMER_SLOTS-1:0] slot_periodic_r;
  logic [ID_BITS-1:0]     slot_ident_r     [TIMER_SLOTS];
  logic [DELAY_BITS-1:0]  slot_period_r    [TIMER_SLOTS];
  logic [DELAY_BITS-1:0]  slot_remaining_r [TIMER_SLOTS];

  logic                  out_valid_r;
  kind_t                 out_kind_r;
  logic [ID_BITS-1:0]    out_result_id_r;
  logic [COUNT_BITS-1:0] out_fired_count_r;
  logic                  out_last_r;

  logic                  in_go;
  logic                  out_free;
  logic                  cur_valid;
  logic [ID_BITS-1:0]    cur_ident;
  logic [DELAY_BITS-1:0] cur_rem;
  logic                  at_end;
  logic [ID_BITS-1:0]    new_id;
  logic                  want_emit;
  kind_t                 emit_kind;
  logic [ID_BITS-1:0]    emit_id;
  logic                  emit_last;
  logic                  step;
  logic                  fin;
  logic                  do_add;
  logic                  do_free;
  logic                  do_reload;
  logic                  do_dec;
  logic                  cnt_inc;

  assign in_go     = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cur_valid = slot_valid_r[idx_r];
  assign cur_ident = slot_ident_r[idx_r];
  assign cur_rem   = slot_remaining_r[idx_r];
  assign at_end    = (idx_r == SLOT_BITS'(TIMER_SLOTS - 1));
  assign new_id    = (next_ident_r + ID_BITS'(1) == '0) ? ID_BITS'(1)
                                                        : next_ident_r + ID_BITS'(1);

  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    want_emit = 1'b0;
    emit_kind = KIND_DONE;
    emit_id   = '0;
    emit_last = 1'b0;
    fin       = 1'b0;
    do_add    = 1'b0;
    do_free   = 1'b0;
    do_reload = 1'b0;
    do_dec    = 1'b0;
    cnt_inc   = 1'b0;
    step      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        case (req_r)
          REQ_ADD: begin
            if (!cur_valid) begin
              want_emit = 1'b1;
              emit_kind = KIND_ADDED;
              emit_id   = new_id;
              do_add    = 1'b1;
              fin       = 1'b1;
            end else if (at_end) begin
              want_emit = 1'b1;
              emit_kind = KIND_FULL;
            end
          end
          REQ_CANCEL: begin
            if (cur_valid && cur_ident == want_r) begin
              want_emit = 1'b1;
              emit_kind = KIND_ABORTED;
              emit_id   = cur_ident;
              do_free   = 1'b1;
              cnt_inc   = 1'b1;
              fin       = 1'b1;
            end else if (at_end) begin
              want_emit = 1'b1;
              emit_kind = KIND_MISS;
              emit_id   = want_r;
            end
          end
          REQ_CANCEL_ALL: begin
            if (cur_valid) begin
              want_emit = 1'b1;
              emit_kind = KIND_ABORTED;
              emit_id   = cur_ident;
              do_free   = 1'b1;
              cnt_inc   = 1'b1;
            end
          end
          REQ_TICK: begin
            if (cur_valid) begin
              if (cur_rem > DELAY_BITS'(1)) begin
                do_dec = 1'b1;
              end else begin
                want_emit = 1'b1;
                emit_kind = KIND_EXPIRED;
                emit_id   = cur_ident;
                cnt_inc   = 1'b1;
                if (slot_periodic_r[idx_r]) begin
                  do_reload = 1'b1;
                end else begin
                  do_free = 1'b1;
                end
              end
            end
          end
          default: begin
          end
        endcase
        step = !want_emit || out_free;
        if (step && (fin || at_end)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        want_emit = 1'b1;
        emit_kind = KIND_DONE;
        emit_last = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hold the request fields for the whole scan
  always_ff @(posedge clk) begin
    if (in_go) begin
      req_r      <= req_t'(in_req_type);
      delay_r    <= in_delay_ms;
      periodic_r <= in_is_periodic;
      want_r     <= in_timer_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else if (in_go) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else if (state_r == ST_SCAN && step) begin
      idx_r <= idx_r + SLOT_BITS'(1);
      if (cnt_inc) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r    <= '0;
      slot_periodic_r <= '0;
      next_ident_r    <= '0;
    end else if (step) begin
      if (do_add) begin
        slot_valid_r[idx_r]    <= 1'b1;
        slot_periodic_r[idx_r] <= periodic_r && (delay_r != '0);
        next_ident_r           <= new_id;
      end
      if (do_free) begin
        slot_valid_r[idx_r]    <= 1'b0;
        slot_periodic_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (do_add) begin
        slot_ident_r[idx_r]     <= new_id;
        slot_period_r[idx_r]    <= delay_r;
        slot_remaining_r[idx_r] <= delay_r;
      end
      if (do_dec) begin
        slot_remaining_r[idx_r] <= cur_rem - DELAY_BITS'(1);
      end
      if (do_reload) begin
        slot_remaining_r[idx_r] <= slot_period_r[idx_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (want_emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (want_emit && out_free) begin
      out_kind_r        <= emit_kind;
      out_result_id_r   <= emit_id;
      out_fired_count_r <= emit_last ? COUNT_BITS'(cnt_r) : '0;
      out_last_r        <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_result_id   = out_result_id_r;
  assign out_fired_count = out_fired_count_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> cnt_r <= CNT_BITS'(TIMER_SLOTS))
    else $error("fired count exceeds slot count");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> state_r == ST_SCAN && idx_r == '0 && cnt_r == '0)
    else $error("accepted beat did not start a scan at slot zero");

  a_done_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_result_id_r == '0 && out_kind_r == KIND_DONE)
    else $error("last beat is not a clean done beat");

  a_added_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_ADDED |-> out_result_id_r != '0)
    else $error("added beat carries id zero");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_timer_queue_manager.sv -----
`default_nettype none

module tb_timer_queue_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import tmq_pkg::*;

  localparam int LIMIT       = 25_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 395;
  localparam int DRAIN       = 2 * TIMER_SLOTS + 8;
  localparam int MAX_SHOWN   = 10;

  typedef struct {
    kind_t                 kind;
    logic [ID_BITS-1:0]    rid;
    logic [COUNT_BITS-1:0] cnt;
    logic                  lst;
  } beat_t;

  typedef struct {
    req_t                  req;
    logic [DELAY_BITS-1:0] delay;
    logic                  per;
    logic [ID_BITS-1:0]    id;
    int                    rep;
    bit                    churn;
    bit                    typed;
    kind_t                 t_kind;
    logic [ID_BITS-1:0]    t_id;
    logic [COUNT_BITS-1:0] t_cnt;
  } row_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [REQ_BITS-1:0]   in_req_type     = '0;
  logic [DELAY_BITS-1:0] in_delay_ms     = '0;
  logic                  in_is_periodic  = 1'b0;
  logic [ID_BITS-1:0]    in_timer_id     = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [KIND_BITS-1:0]  out_kind;
  logic [ID_BITS-1:0]    out_result_id;
  logic [COUNT_BITS-1:0] out_fired_count;
  logic                  out_last;

  int unsigned idle_in_pct  = 0;
  int unsigned idle_out_pct = 0;
  bit          hold_go      = 1'b0;
  int          errors       = 0;
  longint      cycles       = 0;

  bit                    tt_live   [TIMER_SLOTS];
  bit                    tt_per    [TIMER_SLOTS];
  logic [ID_BITS-1:0]    tt_id     [TIMER_SLOTS];
  logic [DELAY_BITS-1:0] tt_period [TIMER_SLOTS];
  logic [DELAY_BITS-1:0] tt_left   [TIMER_SLOTS];
  logic [ID_BITS-1:0]    tt_last_id;

  beat_t step_beats[$];
  beat_t pending_beats[$];
  row_t  plan[$];

  timer_queue_manager u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_delay_ms     (in_delay_ms),
    .in_is_periodic  (in_is_periodic),
    .in_timer_id     (in_timer_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_result_id   (out_result_id),
    .out_fired_count (out_fired_count),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void push_beat(kind_t k, logic [ID_BITS-1:0] id,
                                    logic [COUNT_BITS-1:0] c, logic l);
    beat_t b;
    b.kind = k;
    b.rid  = id;
    b.cnt  = c;
    b.lst  = l;
    step_beats.push_back(b);
  endfunction

  function automatic void timer_table_step(req_t req, logic [DELAY_BITS-1:0] delay,
                                           logic per, logic [ID_BITS-1:0] want);
    int                 hit;
    int unsigned        fired;
    logic [ID_BITS-1:0] nid;
    hit   = -1;
    fired = 0;
    step_beats.delete();
    case (req)
      REQ_ADD: begin
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (!tt_live[s] && hit < 0) hit = s;
        end
        if (hit < 0) begin
          push_beat(KIND_FULL, '0, '0, 1'b0);
        end else begin
          nid = tt_last_id + 1'b1;
          if (nid == '0) nid = ID_BITS'(1);
          tt_last_id     = nid;
          tt_live[hit]   = 1'b1;
          tt_per[hit]    = per && (delay != '0);
          tt_id[hit]     = nid;
          tt_period[hit] = delay;
          tt_left[hit]   = delay;
          push_beat(KIND_ADDED, nid, '0, 1'b0);
        end
      end
      REQ_CANCEL: begin
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (tt_live[s] && tt_id[s] == want && hit < 0) hit = s;
        end
        if (hit < 0) begin
          push_beat(KIND_MISS, want, '0, 1'b0);
        end else begin
          push_beat(KIND_ABORTED, tt_id[hit], '0, 1'b0);
          tt_live[hit] = 1'b0;
          tt_per[hit]  = 1'b0;
          fired        = 1;
        end
      end
      REQ_CANCEL_ALL: begin
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (tt_live[s]) begin
            push_beat(KIND_ABORTED, tt_id[s], '0, 1'b0);
            tt_live[s] = 1'b0;
            tt_per[s]  = 1'b0;
            fired++;
          end
        end
      end
      default: begin
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (tt_live[s]) begin
            if (tt_left[s] > 1) begin
              tt_left[s] = tt_left[s] - 1'b1;
            end else begin
              push_beat(KIND_EXPIRED, tt_id[s], '0, 1'b0);
              fired++;
              if (tt_per[s]) begin
                tt_left[s] = tt_period[s];
              end else begin
                tt_live[s] = 1'b0;
                tt_per[s]  = 1'b0;
              end
            end
          end
        end
      end
    endcase
    push_beat(KIND_DONE, '0, fired[COUNT_BITS-1:0], 1'b1);
  endfunction

  task automatic note_error(string msg);
    if (errors < MAX_SHOWN) $display("%s", msg);
    errors++;
  endtask

  task automatic send_item(req_t r, logic [DELAY_BITS-1:0] d, logic p,
                           logic [ID_BITS-1:0] id, bit typed, kind_t tk,
                           logic [ID_BITS-1:0] tid, logic [COUNT_BITS-1:0] tc);
    beat_t b;
    @(negedge clk);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= r;
    in_delay_ms    <= d;
    in_is_periodic <= p;
    in_timer_id    <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    timer_table_step(r, d, p, id);
    if (typed) begin
      if (tk != KIND_DONE) begin
        b.kind = tk;
        b.rid  = tid;
        b.cnt  = '0;
        b.lst  = 1'b0;
        pending_beats.push_back(b);
      end
      b.kind = KIND_DONE;
      b.rid  = '0;
      b.cnt  = tc;
      b.lst  = 1'b1;
      pending_beats.push_back(b);
    end else begin
      foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    end
  endtask

  function automatic void add_row(req_t r, int d, bit p, int id, int rep, bit churn,
                                  bit typed, kind_t tk, int tid, int tc);
    row_t w;
    w.req    = r;
    w.delay  = DELAY_BITS'(d);
    w.per    = p;
    w.id     = ID_BITS'(id);
    w.rep    = rep;
    w.churn  = churn;
    w.typed  = typed;
    w.t_kind = tk;
    w.t_id   = ID_BITS'(tid);
    w.t_cnt  = COUNT_BITS'(tc);
    plan.push_back(w);
  endfunction

  always @(posedge clk) begin
    beat_t b;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        note_error($sformatf("unexpected beat: kind %0d id %0d cnt %0d last %0d",
                             out_kind, out_result_id, out_fired_count, out_last));
      end else begin
        b = pending_beats.pop_front();
        if (out_kind !== b.kind || out_result_id !== b.rid ||
            out_fired_count !== b.cnt || out_last !== b.lst) begin
          note_error($sformatf(
            "mismatch: exp kind %0d id %0d cnt %0d last %0d, got kind %0d id %0d cnt %0d last %0d",
            b.kind, b.rid, b.cnt, b.lst,
            out_kind, out_result_id, out_fired_count, out_last));
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < idle_out_pct);
    end
  end

  initial begin
    int unsigned           roll;
    int unsigned           pick;
    int unsigned           saved_in;
    int unsigned           saved_out;
    req_t                  r;
    logic [DELAY_BITS-1:0] d;
    logic                  p;
    logic [ID_BITS-1:0]    id;
    logic [ID_BITS-1:0]    live_ids[$];

    for (int s = 0; s < TIMER_SLOTS; s++) begin
      tt_live[s]   = 1'b0;
      tt_per[s]    = 1'b0;
      tt_id[s]     = '0;
      tt_period[s] = '0;
      tt_left[s]   = '0;
    end
    tt_last_id = '0;

    add_row(REQ_TICK,       0,     0, 0,     1, 0, 1, KIND_DONE,    0,     0);
    add_row(REQ_CANCEL_ALL, 0,     0, 0,     1, 0, 1, KIND_DONE,    0,     0);
    add_row(REQ_CANCEL,     0,     0, 0,     1, 0, 1, KIND_MISS,    0,     0);
    add_row(REQ_ADD,        0,     1, 0,     1, 0, 1, KIND_ADDED,   1,     0);
    add_row(REQ_TICK,       0,     0, 0,     1, 0, 1, KIND_EXPIRED, 1,     1);
    add_row(REQ_TICK,       0,     0, 0,     1, 0, 1, KIND_DONE,    0,     0);
    add_row(REQ_ADD,        65535, 0, 0,     1, 0, 1, KIND_ADDED,   2,     0);
    add_row(REQ_ADD,        1,     1, 0,     1, 0, 1, KIND_ADDED,   3,     0);
    add_row(REQ_ADD,        2,     1, 0,     1, 0, 1, KIND_ADDED,   4,     0);
    add_row(REQ_TICK,       0,     0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_TICK,       0,     0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_CANCEL,     0,     0, 4,     1, 0, 1, KIND_ABORTED, 4,     1);
    add_row(REQ_CANCEL,     0,     0, 4,     1, 0, 1, KIND_MISS,    4,     0);
    add_row(REQ_CANCEL,     0,     0, 65535, 1, 0, 1, KIND_MISS,    65535, 0);
    add_row(REQ_CANCEL_ALL, 0,     0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_ADD,        16'hA5A5, 1, 0,  TIMER_SLOTS, 0, 0, KIND_DONE, 0, 0);
    add_row(REQ_ADD,        7,     0, 0,     1, 0, 1, KIND_FULL,    0,     0);
    add_row(REQ_TICK,       0,     0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_CANCEL,     0,     0, 20,    1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_ADD,        3,     0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_CANCEL_ALL, 0,     0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_ADD,        60000, 0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_ADD,        9,     0, 0,     1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_CANCEL,     0,     0, 38,    1, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_TICK,       0,     0, 0,     9, 0, 0, KIND_DONE,    0,     0);
    add_row(REQ_CANCEL,     0,     0, 38,    1, 0, 1, KIND_MISS,    38,    0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_in_pct  = 31;
    idle_out_pct = 51;

    foreach (plan[k]) begin
      saved_in  = idle_in_pct;
      saved_out = idle_out_pct;
      if (plan[k].churn) begin
        idle_in_pct  = 0;
        idle_out_pct = 0;
      end
      for (int n = 0; n < plan[k].rep; n++) begin
        send_item(plan[k].req, plan[k].delay, plan[k].per, plan[k].id,
                  plan[k].typed, plan[k].t_kind, plan[k].t_id, plan[k].t_cnt);
        if (plan[k].churn) begin
          send_item(REQ_CANCEL, '0, 1'b0, tt_last_id, 1'b0, KIND_DONE, '0, '0);
        end
      end
      idle_in_pct  = saved_in;
      idle_out_pct = saved_out;
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        idle_in_pct  = 51;
        idle_out_pct = 31;
      end
      if (i == 2 * RAND_ITEMS / 3) begin
        idle_in_pct  = 0;
        idle_out_pct = 0;
        hold_go      = 1'b1;
      end
      roll = $urandom_range(99);
      d    = DELAY_BITS'($urandom);
      p    = 1'($urandom_range(1));
      id   = ID_BITS'($urandom);
      if (roll < 40) begin
        r    = REQ_ADD;
        pick = $urandom_range(99);
        if (pick < 70) d = DELAY_BITS'($urandom_range(8));
        else if (pick < 85) d = DELAY_BITS'($urandom_range(40, 9));
        else if (pick < 90) d = '1;
      end else if (roll < 75) begin
        r = REQ_TICK;
      end else if (roll < 93) begin
        r = REQ_CANCEL;
        live_ids.delete();
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (tt_live[s]) live_ids.push_back(tt_id[s]);
        end
        pick = $urandom_range(99);
        if (pick < 80 && live_ids.size() > 0) begin
          id = live_ids[$urandom_range(live_ids.size() - 1)];
        end else if (pick < 85) begin
          id = '0;
        end
      end else begin
        r = REQ_CANCEL_ALL;
      end
      send_item(r, d, p, id, 1'b0, KIND_DONE, '0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/tmq_pkg.sv
design/timer_queue_manager.sv
dv/tb_timer_queue_manager.sv
